FILE: sv/esd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DROP = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } esd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_item;
  } esd_out_t;

  // decoded request for the back end: value, then literal bytes, then end marker
  typedef struct packed {
    logic            val_vld;
    logic            val_utf;
    logic [31:0]     val_code;
    logic [1:0]      lit_n;
    logic [2:0][7:0] lit;
    logic            marker;
  } esd_act_t;

  function automatic logic [2:0] utf8_len(input logic [31:0] code);
    logic [2:0] len;
    if (code <= 32'h0000_007F) begin
      len = 3'd1;
    end else if (code <= 32'h0000_07FF) begin
      len = 3'd2;
    end else if (code <= 32'h0000_FFFF) begin
      len = 3'd3;
    end else if (code <= 32'h001F_FFFF) begin
      len = 3'd4;
    end else if (code <= 32'h03FF_FFFF) begin
      len = 3'd5;
    end else if (code <= 32'h7FFF_FFFF) begin
      len = 3'd6;
    end else begin
      len = 3'd7;
    end
    return len;
  endfunction

  // pos 0 is the lead byte
  function automatic logic [7:0] utf8_byte(input logic [31:0] code, input logic [2:0] len,
                                           input logic [2:0] pos);
    logic [2:0]  k;
    logic [31:0] sh;
    logic [7:0]  mask;
    logic [7:0]  b;
    k  = len - 3'd1 - pos;
    sh = code >> ({3'd0, k} * 6'd6);
    unique case (len)
      3'd2:    mask = 8'hC0;
      3'd3:    mask = 8'hE0;
      3'd4:    mask = 8'hF0;
      3'd5:    mask = 8'hF8;
      3'd6:    mask = 8'hFC;
      3'd7:    mask = 8'hFE;
      default: mask = 8'h00;
    endcase
    if (pos == 3'd0) begin
      b = mask | sh[7:0];
    end else begin
      b = 8'h80 | {2'b00, sh[5:0]};
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: sv/esd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module esd_front import esd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire esd_in_t  in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output esd_act_t      q_data
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_BSL    = 9'b000000010,
    ST_OCT    = 9'b000000100,
    ST_XSTART = 9'b000001000,
    ST_HEX    = 9'b000010000,
    ST_USTART = 9'b000100000,
    ST_U4     = 9'b001000000,
    ST_U8     = 9'b010000000,
    ST_CTRL   = 9'b100000000
  } esd_state_t;

  localparam logic [7:0] CH_BSL = 8'h5C;

  esd_state_t  st_r, st_nxt;
  logic [3:0]  dc_r, dc_nxt;
  logic [31:0] cv_r, cv_nxt;
  esd_act_t    act;
  logic        acc;

  function automatic esd_act_t add_lit(input esd_act_t a, input logic [7:0] b);
    esd_act_t r;
    r = a;
    r.lit[r.lit_n] = b;
    r.lit_n = r.lit_n + 2'd1;
    return r;
  endfunction

  function automatic esd_act_t add_val(input esd_act_t a, input logic utf,
                                       input logic [31:0] code);
    esd_act_t r;
    r = a;
    r.val_vld  = 1'b1;
    r.val_utf  = utf;
    r.val_code = code;
    return r;
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, c[3:0]};
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic        dv;
    logic [3:0]  d;
    logic        is_oct;
    logic [10:0] oct_sum;
    logic [3:0]  dc_inc;
    logic [3:0]  limit;
    logic        utf;
    c       = in_data.in_byte;
    {dv, d} = hex_digit(c);
    is_oct  = (c >= "0") && (c <= "7");
    oct_sum = {cv_r[7:0], 3'b000} + {8'd0, c[2:0]};
    dc_inc  = dc_r + 4'd1;
    limit   = (st_r == ST_HEX) ? 4'd2 : (st_r == ST_U4) ? 4'd4 : 4'd8;
    utf     = (st_r == ST_U4) || (st_r == ST_U8);
    act     = '0;
    st_nxt  = st_r;
    dc_nxt  = dc_r;
    cv_nxt  = cv_r;
    unique case (st_r)
      ST_BSL: begin
        st_nxt = ST_IDLE;
        dc_nxt = 4'd0;
        cv_nxt = 32'd0;
        unique case (c)
          "a":           act = add_lit(act, 8'h07);
          "b":           act = add_lit(act, 8'h08);
          "e", "E":      act = add_lit(act, 8'h1B);
          "f":           act = add_lit(act, 8'h0C);
          "n":           act = add_lit(act, 8'h0A);
          "r":           act = add_lit(act, 8'h0D);
          "t":           act = add_lit(act, 8'h09);
          "v":           act = add_lit(act, 8'h0B);
          CH_BSL, "'", "\"", "?": act = add_lit(act, c);
          "x":           st_nxt = ST_XSTART;
          "u":           st_nxt = ST_USTART;
          "U":           st_nxt = ST_U8;
          "c":           st_nxt = ST_CTRL;
          default: begin
            if (is_oct) begin
              st_nxt = ST_OCT;
              cv_nxt = {29'd0, c[2:0]};
              dc_nxt = 4'd1;
            end else begin
              act = add_lit(act, CH_BSL);
              act = add_lit(act, c);
            end
          end
        endcase
      end
      ST_OCT: begin
        if (is_oct && dc_r < 4'd3 && oct_sum <= 11'd255) begin
          cv_nxt = {21'd0, oct_sum};
          dc_nxt = dc_inc;
          if (dc_inc >= 4'd3) begin
            act    = add_val(act, 1'b0, {21'd0, oct_sum});
            st_nxt = ST_IDLE;
            dc_nxt = 4'd0;
            cv_nxt = 32'd0;
          end
        end else begin
          act    = add_val(act, 1'b0, cv_r);
          dc_nxt = 4'd0;
          cv_nxt = 32'd0;
          if (c == CH_BSL) begin
            st_nxt = ST_BSL;
          end else begin
            st_nxt = ST_IDLE;
            act    = add_lit(act, c);
          end
        end
      end
      ST_XSTART, ST_USTART: begin
        if (dv) begin
          st_nxt = (st_r == ST_XSTART) ? ST_HEX : ST_U4;
          cv_nxt = {28'd0, d};
          dc_nxt = 4'd1;
        end else begin
          act = add_lit(act, CH_BSL);
          act = add_lit(act, (st_r == ST_XSTART) ? 8'("x") : 8'("u"));
          if (c == CH_BSL) begin
            st_nxt = ST_BSL;
          end else begin
            st_nxt = ST_IDLE;
            act    = add_lit(act, c);
          end
        end
      end
      ST_HEX, ST_U4, ST_U8: begin
        if (dv && dc_r < limit) begin
          cv_nxt = {cv_r[27:0], d};
          dc_nxt = dc_inc;
          if (dc_inc >= limit) begin
            act    = add_val(act, utf, {cv_r[27:0], d});
            st_nxt = ST_IDLE;
            dc_nxt = 4'd0;
            cv_nxt = 32'd0;
          end
        end else begin
          act    = add_val(act, utf, cv_r);
          dc_nxt = 4'd0;
          cv_nxt = 32'd0;
          if (c == CH_BSL) begin
            st_nxt = ST_BSL;
          end else begin
            st_nxt = ST_IDLE;
            act    = add_lit(act, c);
          end
        end
      end
      ST_CTRL: begin
        st_nxt = ST_IDLE;
        act    = add_val(act, 1'b0, {27'd0, c[4:0]});
      end
      default: begin
        if (c == CH_BSL) begin
          st_nxt = ST_BSL;
        end else begin
          st_nxt = ST_IDLE;
          act    = add_lit(act, c);
        end
      end
    endcase

    if (in_data.end_of_text) begin
      unique case (st_nxt)
        ST_BSL:    act = add_lit(act, CH_BSL);
        ST_XSTART: begin
          act = add_lit(act, CH_BSL);
          act = add_lit(act, 8'("x"));
        end
        ST_USTART: begin
          act = add_lit(act, CH_BSL);
          act = add_lit(act, 8'("u"));
        end
        ST_CTRL: begin
          act = add_lit(act, CH_BSL);
          act = add_lit(act, 8'("c"));
        end
        ST_OCT, ST_HEX: act = add_val(act, 1'b0, cv_nxt);
        ST_U4, ST_U8:   act = add_val(act, 1'b1, cv_nxt);
        default: ;
      endcase
      act.marker = 1'b1;
      st_nxt     = ST_IDLE;
      dc_nxt     = 4'd0;
      cv_nxt     = 32'd0;
    end
  end

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc && (act.val_vld || (act.lit_n != 2'd0) || act.marker);
  assign q_data   = act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      dc_r <= 4'd0;
      cv_r <= 32'd0;
    end else if (acc) begin
      st_r <= st_nxt;
      dc_r <= dc_nxt;
      cv_r <= cv_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/esd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module esd_queue import esd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire esd_act_t push_data,
  output logic          full,
  input  wire logic     pop,
  output esd_act_t      head,
  output logic          head_vld
);

  esd_act_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_pop;

  assign full     = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = mem_r[rp_r];
  assign do_pop   = pop && head_vld;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W + 1)'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/esd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module esd_back import esd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire esd_act_t q_head,
  input  wire logic     q_vld,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output esd_out_t      out_data
);

  esd_act_t   cur_r;
  logic       cur_vld_r;
  logic [3:0] idx_r;
  logic [2:0] nv_r;
  logic [3:0] tot_r;
  logic       out_vld_r;
  esd_out_t   out_r;

  logic       emit;
  logic       last;
  logic       load;
  logic [2:0] nv_ld;
  logic [3:0] tot_ld;
  esd_out_t   res;

  assign emit  = cur_vld_r && (!out_vld_r || out_ready);
  assign last  = (idx_r == tot_r - 4'd1);
  assign load  = !cur_vld_r || (emit && last);
  assign q_pop = load;

  assign nv_ld  = q_head.val_vld ? (q_head.val_utf ? utf8_len(q_head.val_code) : 3'd1) : 3'd0;
  assign tot_ld = {1'b0, nv_ld} + {2'b00, q_head.lit_n} + {3'd0, q_head.marker};

  always_comb begin
    logic [3:0] lit_pos;
    lit_pos          = idx_r - {1'b0, nv_r};
    res.last_of_item = last;
    if (idx_r < {1'b0, nv_r}) begin
      if (cur_r.val_code == 32'd0) begin
        res.out_byte = 8'd0;
        res.kind     = KIND_DROP;
      end else if (cur_r.val_utf) begin
        res.out_byte = utf8_byte(cur_r.val_code, nv_r, idx_r[2:0]);
        res.kind     = KIND_DATA;
      end else begin
        res.out_byte = cur_r.val_code[7:0];
        res.kind     = KIND_DATA;
      end
    end else if (idx_r < ({1'b0, nv_r} + {2'b00, cur_r.lit_n})) begin
      res.out_byte = cur_r.lit[lit_pos[1:0]];
      res.kind     = KIND_DATA;
    end else begin
      res.out_byte = 8'd0;
      res.kind     = KIND_END;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_head;
      nv_r  <= nv_ld;
      tot_r <= tot_ld;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 4'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        cur_vld_r <= q_vld;
        idx_r     <= 4'd0;
      end else if (emit) begin
        idx_r <= idx_r + 4'd1;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_tot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (tot_r != 4'd0))
    else $error("request in progress with no results");

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (idx_r == 4'd0))
    else $error("result index did not restart after last result");

  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_vld_r && !emit) |=> (cur_vld_r && $stable(idx_r)))
    else $error("request advanced while output stalled");

endmodule

`default_nettype wire

FILE: sv/escape_sequence_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// backslash escape decoder for quoted-string bodies, one byte per request in,
// one decoded byte (or drop / end marker) per result out. a request is taken
// in every cycle while the two-entry queue between the classifier and the
// result expander has room; the expander sends one result per cycle while
// out_ready does not stall it, so a request that yields n results (0 to 8,
// up to 7 for a utf-8 code point) holds the expander until all n are sent
// and the sustained rate is set by that expander. the first result passes through
// the queue, the request register and the output register to reach out_valid.

module escape_sequence_decoder_unit import esd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire esd_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output esd_out_t      out_data
);

  logic     q_full;
  logic     q_push;
  esd_act_t q_wdata;
  logic     q_pop;
  esd_act_t q_head;
  logic     q_vld;

  esd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  esd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .head_vld  (q_vld)
  );

  esd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_vld     (q_vld),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: dv/escape_sequence_decoder_unit_tb.sv
`timescale 1ns / 1ps

module escape_sequence_decoder_unit_tb;
  import esd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BSL, ST_OCT, ST_XSTART, ST_HEX, ST_USTART, ST_U4, ST_U8, ST_CTRL
  } esc_state_t;

  typedef struct {
    esd_in_t     req;
    int unsigned phase;
    bit          hold;
  } pending_req_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  esd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  esd_out_t out_data;

  pending_req_t req_q[$];
  esd_out_t     decoded_q[$];
  esd_out_t     step_res[$];
  esd_out_t     want;

  esc_state_t  esc_st = ST_IDLE;
  logic [3:0]  esc_ndig = '0;
  logic [31:0] esc_acc = '0;

  int unsigned send_idle_pct[3] = '{12, 66, 0};
  int unsigned recv_stall_pct[3] = '{66, 12, 0};
  int unsigned cur_phase = 0;
  int unsigned gen_phase = 0;
  bit          gen_hold = 1'b0;
  int unsigned n_err = 0;

  logic [7:0] esc_letters[13] = '{"a", "b", "e", "E", "f", "n", "r", "t", "v", "\\", "'",
                                  "\"", "?"};

  escape_sequence_decoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // decoder prediction

  task automatic put_result(input logic [7:0] b, input logic [1:0] k);
    esd_out_t r;
    r.out_byte     = b;
    r.kind         = k;
    r.last_of_item = 1'b0;
    step_res.push_back(r);
  endtask

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") begin
      return {1'b1, ch[3:0]};
    end
    if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")) begin
      return {1'b1, ch[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  task automatic put_code_point(input logic [31:0] cp);
    int         n;
    logic [63:0] w;
    logic [7:0]  lead;
    w = {32'd0, cp};
    if (cp <= 32'h7F) begin
      put_result(cp[7:0], KIND_DATA);
      return;
    end
    if (cp <= 32'h0000_07FF) n = 2;
    else if (cp <= 32'h0000_FFFF) n = 3;
    else if (cp <= 32'h001F_FFFF) n = 4;
    else if (cp <= 32'h03FF_FFFF) n = 5;
    else if (cp <= 32'h7FFF_FFFF) n = 6;
    else n = 7;
    lead = 8'hFF << (8 - n);
    put_result(lead | 8'(w >> (6 * (n - 1))), KIND_DATA);
    for (int i = n - 1; i > 0; i--) begin
      put_result(8'h80 | {2'b00, 6'(w >> (6 * (i - 1)))}, KIND_DATA);
    end
  endtask

  task automatic close_value();
    if (esc_acc == 32'd0) begin
      put_result(8'h00, KIND_DROP);
    end else if (esc_st == ST_U4 || esc_st == ST_U8) begin
      put_code_point(esc_acc);
    end else begin
      put_result(esc_acc[7:0], KIND_DATA);
    end
    esc_st   = ST_IDLE;
    esc_ndig = '0;
    esc_acc  = '0;
  endtask

  task automatic plain_text(input logic [7:0] ch);
    if (ch == "\\") begin
      esc_st = ST_BSL;
    end else begin
      put_result(ch, KIND_DATA);
    end
  endtask

  task automatic after_backslash(input logic [7:0] ch);
    esc_st   = ST_IDLE;
    esc_ndig = '0;
    esc_acc  = '0;
    case (ch)
      "a": put_result(8'h07, KIND_DATA);
      "b": put_result(8'h08, KIND_DATA);
      "e", "E": put_result(8'h1B, KIND_DATA);
      "f": put_result(8'h0C, KIND_DATA);
      "n": put_result(8'h0A, KIND_DATA);
      "r": put_result(8'h0D, KIND_DATA);
      "t": put_result(8'h09, KIND_DATA);
      "v": put_result(8'h0B, KIND_DATA);
      "\\", "'", "\"", "?": put_result(ch, KIND_DATA);
      "x": esc_st = ST_XSTART;
      "u": esc_st = ST_USTART;
      "U": esc_st = ST_U8;
      "c": esc_st = ST_CTRL;
      default: begin
        if (ch >= "0" && ch <= "7") begin
          esc_st   = ST_OCT;
          esc_acc  = {29'd0, ch[2:0]};
          esc_ndig = 4'd1;
        end else begin
          put_result("\\", KIND_DATA);
          put_result(ch, KIND_DATA);
        end
      end
    endcase
  endtask

  task automatic take_byte(input logic [7:0] ch);
    logic [4:0]  hd;
    logic [3:0]  lim;
    logic [31:0] oct_next;
    hd       = hex_digit(ch);
    oct_next = {esc_acc[28:0], 3'b000} + {29'd0, ch[2:0]};
    case (esc_st)
      ST_BSL: after_backslash(ch);
      ST_OCT: begin
        if (ch >= "0" && ch <= "7" && esc_ndig < 4'd3 && oct_next <= 32'd255) begin
          esc_acc  = oct_next;
          esc_ndig = esc_ndig + 4'd1;
          if (esc_ndig >= 4'd3) close_value();
        end else begin
          close_value();
          plain_text(ch);
        end
      end
      ST_XSTART, ST_USTART: begin
        if (hd[4]) begin
          esc_st   = (esc_st == ST_XSTART) ? ST_HEX : ST_U4;
          esc_acc  = {28'd0, hd[3:0]};
          esc_ndig = 4'd1;
        end else begin
          put_result("\\", KIND_DATA);
          put_result((esc_st == ST_XSTART) ? "x" : "u", KIND_DATA);
          esc_st = ST_IDLE;
          plain_text(ch);
        end
      end
      ST_HEX, ST_U4, ST_U8: begin
        lim = (esc_st == ST_HEX) ? 4'd2 : (esc_st == ST_U4) ? 4'd4 : 4'd8;
        if (hd[4] && esc_ndig < lim) begin
          esc_acc  = {esc_acc[27:0], hd[3:0]};
          esc_ndig = esc_ndig + 4'd1;
          if (esc_ndig >= lim) close_value();
        end else begin
          close_value();
          plain_text(ch);
        end
      end
      ST_CTRL: begin
        esc_st = ST_IDLE;
        if (ch[4:0] != 5'd0) begin
          put_result({3'b000, ch[4:0]}, KIND_DATA);
        end else begin
          put_result(8'h00, KIND_DROP);
        end
      end
      default: begin
        esc_st = ST_IDLE;
        plain_text(ch);
      end
    endcase
  endtask

  task automatic flush_text_end();
    case (esc_st)
      ST_BSL: put_result("\\", KIND_DATA);
      ST_XSTART: begin
        put_result("\\", KIND_DATA);
        put_result("x", KIND_DATA);
      end
      ST_USTART: begin
        put_result("\\", KIND_DATA);
        put_result("u", KIND_DATA);
      end
      ST_CTRL: begin
        put_result("\\", KIND_DATA);
        put_result("c", KIND_DATA);
      end
      ST_OCT, ST_HEX, ST_U4, ST_U8: close_value();
      default: ;
    endcase
    put_result(8'h00, KIND_END);
    esc_st   = ST_IDLE;
    esc_ndig = '0;
    esc_acc  = '0;
  endtask

  task automatic decode_request(input esd_in_t rq);
    step_res.delete();
    take_byte(rq.in_byte);
    if (rq.end_of_text) flush_text_end();
    if (step_res.size() != 0) step_res[step_res.size() - 1].last_of_item = 1'b1;
    foreach (step_res[i]) decoded_q.push_back(step_res[i]);
  endtask

  // request generation

  function automatic bit coin(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + v;
    return (coin(50) ? "a" : "A") + v - 8'd10;
  endfunction

  task automatic add_req(input logic [7:0] b, input logic eot);
    pending_req_t p;
    p.req.in_byte     = b;
    p.req.end_of_text = eot;
    p.phase           = gen_phase;
    p.hold            = gen_hold;
    gen_hold          = 1'b0;
    req_q.push_back(p);
  endtask

  task automatic add_digits(input int n, input bit octal);
    for (int i = 0; i < n; i++) begin
      if (octal) add_req("0" + 8'($urandom_range(7)), coin(5));
      else add_req(hex_char(4'($urandom_range(15))), coin(5));
    end
    if (coin(50)) add_req(8'($urandom_range(255)), coin(5));
  endtask

  task automatic add_seq();
    int form;
    form = $urandom_range(9);
    if (form == 0 || form == 9) begin
      repeat ($urandom_range(1, 3)) add_req(8'($urandom_range(255)), coin(5));
    end else begin
      add_req("\\", coin(3));
      case (form)
        1: add_req(esc_letters[$urandom_range(12)], coin(5));
        2: add_digits($urandom_range(1, 3), 1'b1);
        3: begin
          add_req("x", coin(5));
          add_digits($urandom_range(0, 3), 1'b0);
        end
        4: begin
          add_req("u", coin(5));
          add_digits($urandom_range(0, 5), 1'b0);
        end
        5, 6: begin
          add_req("U", coin(5));
          add_digits($urandom_range(0, 9), 1'b0);
        end
        7: begin
          add_req("c", coin(5));
          add_req(8'($urandom_range(255)), coin(5));
        end
        default: add_req(8'($urandom_range(255)), coin(5));
      endcase
    end
  endtask

  // driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_request(in_data);
        req_q.delete(0);
      end
      if (!in_valid || in_ready) begin
        if (req_q.size() != 0 && !(req_q[0].hold && decoded_q.size() != 0) &&
            $urandom_range(99) >= send_idle_pct[req_q[0].phase]) begin
          in_valid  <= 1'b1;
          in_data   <= req_q[0].req;
          cur_phase <= req_q[0].phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result byte %h kind %0d last %0b", $time,
                   out_data.out_byte, out_data.kind, out_data.last_of_item);
          n_err++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.kind !== want.kind ||
              out_data.last_of_item !== want.last_of_item) begin
            $display("%0t: expected byte %h kind %0d last %0b, got byte %h kind %0d last %0b",
                     $time, want.out_byte, want.kind, want.last_of_item,
                     out_data.out_byte, out_data.kind, out_data.last_of_item);
            n_err++;
          end
        end
      end
      out_ready <= $urandom_range(99) >= recv_stall_pct[cur_phase];
    end
  end

  initial begin
    int n_dir;
    int p;
    add_req(8'h00, 1'b0);
    add_req(8'hFF, 1'b0);
    add_req("\\", 1'b0);
    add_req("q", 1'b0);
    add_req("\\", 1'b0);
    add_req("4", 1'b0);
    add_req("0", 1'b0);
    add_req("0", 1'b0);
    add_req("\\", 1'b0);
    add_req("x", 1'b0);
    add_req("G", 1'b0);
    add_req("\\", 1'b0);
    add_req("c", 1'b0);
    add_req(8'h40, 1'b0);
    add_req("\\", 1'b0);
    add_req("U", 1'b0);
    add_req("Z", 1'b0);
    add_req("\\", 1'b1);
    add_req("\\", 1'b0);
    add_req("u", 1'b0);
    add_req("1", 1'b1);
    add_req("\\", 1'b0);
    add_req("x", 1'b1);
    add_req("\\", 1'b0);
    add_req("c", 1'b1);
    n_dir = req_q.size();
    gen_hold = 1'b1;
    while (req_q.size() < 110) begin
      p = (req_q.size() - n_dir) * 3 / (110 - n_dir);
      if (p > 2) p = 2;
      if (p != gen_phase) gen_hold = 1'b1;
      gen_phase = p;
      add_seq();
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (req_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
